// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the compensation unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/bptc_pkg.sv -----
// Package with types, constants and the micro-op program of the compensation unit.
package bptc_pkg;

    localparam logic [63:0] C_128000   = 64'd128000;
    localparam logic [63:0] C_1048576  = 64'd1048576;
    localparam logic [63:0] C_3125     = 64'd3125;
    localparam logic [63:0] C_5        = 64'd5;
    localparam logic [63:0] C_128      = 64'd128;
    localparam logic [63:0] C_2_POW_47 = 64'h0000_8000_0000_0000;

    localparam int unsigned PC_W = 6;
    localparam logic [PC_W-1:0] TEMP_PC  = 6'd0;
    localparam logic [PC_W-1:0] PRESS_PC = 6'd13;

    localparam logic [2:0] CFG_TEMP   = 3'd0;
    localparam logic [2:0] CFG_PLOW   = 3'd1;
    localparam logic [2:0] CFG_PHIGH  = 3'd2;
    localparam logic [2:0] CFG_PNINE  = 3'd3;

    typedef enum logic [2:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_ASR, OP_SHL, OP_DIV, OP_ZCHK, OP_DONE
    } t_op;

    typedef enum logic [2:0] {
        DST_V1, DST_V2, DST_P, DST_AUX, DST_X, DST_PS, DST_FT
    } t_dst;

    typedef enum logic [4:0] {
        SRC_ZERO, SRC_V1, SRC_V2, SRC_P, SRC_AUX, SRC_X, SRC_PS, SRC_FTX,
        SRC_ADC, SRC_ADC_SH3, SRC_ADC_SH4, SRC_T1, SRC_T1_SH1, SRC_T2, SRC_T3,
        SRC_P1, SRC_P2, SRC_P3, SRC_P4, SRC_P5, SRC_P6, SRC_P7, SRC_P8, SRC_P9,
        SRC_C5, SRC_C128, SRC_C128000, SRC_C1048576, SRC_C3125, SRC_C2_47
    } t_src;

    typedef struct packed {
        t_op        op;
        t_dst       dst;
        t_src       a;
        t_src       b;
        logic [5:0] sh;
        logic       w32;
    } t_uop;

    typedef struct packed {
        logic       start;
        t_op        op;
        logic [5:0] sh;
    } t_alu_cmd;

    typedef enum logic [1:0] {ALU_IDLE, ALU_MUL, ALU_DIV, ALU_FIX} t_alu_st;
    typedef enum logic [1:0] {SEQ_IDLE, SEQ_ISSUE, SEQ_WAIT, SEQ_OUT} t_seq_st;

    function automatic t_uop mk(t_op op, t_dst dst, t_src a, t_src b,
                                logic [5:0] sh, logic w32);
        t_uop u;
        u.op = op; u.dst = dst; u.a = a; u.b = b; u.sh = sh; u.w32 = w32;
        return u;
    endfunction

    // Temperature program first, pressure program from PRESS_PC.
    function automatic t_uop uop_rom(logic [PC_W-1:0] pc);
        t_uop u;
        case (pc)
            6'd0:  u = mk(OP_SUB, DST_V1, SRC_ADC_SH3, SRC_T1_SH1, 6'd0, 1'b1);
            6'd1:  u = mk(OP_MUL, DST_V1, SRC_V1, SRC_T2, 6'd0, 1'b1);
            6'd2:  u = mk(OP_ASR, DST_V1, SRC_V1, SRC_ZERO, 6'd11, 1'b1);
            6'd3:  u = mk(OP_SUB, DST_V2, SRC_ADC_SH4, SRC_T1, 6'd0, 1'b1);
            6'd4:  u = mk(OP_MUL, DST_V2, SRC_V2, SRC_V2, 6'd0, 1'b1);
            6'd5:  u = mk(OP_ASR, DST_V2, SRC_V2, SRC_ZERO, 6'd12, 1'b1);
            6'd6:  u = mk(OP_MUL, DST_V2, SRC_V2, SRC_T3, 6'd0, 1'b1);
            6'd7:  u = mk(OP_ASR, DST_V2, SRC_V2, SRC_ZERO, 6'd14, 1'b1);
            6'd8:  u = mk(OP_ADD, DST_FT, SRC_V1, SRC_V2, 6'd0, 1'b1);
            6'd9:  u = mk(OP_MUL, DST_P, SRC_FTX, SRC_C5, 6'd0, 1'b1);
            6'd10: u = mk(OP_ADD, DST_P, SRC_P, SRC_C128, 6'd0, 1'b1);
            6'd11: u = mk(OP_ASR, DST_P, SRC_P, SRC_ZERO, 6'd8, 1'b1);
            6'd12: u = mk(OP_DONE, DST_P, SRC_ZERO, SRC_ZERO, 6'd0, 1'b0);
            6'd13: u = mk(OP_SUB, DST_V1, SRC_FTX, SRC_C128000, 6'd0, 1'b0);
            6'd14: u = mk(OP_MUL, DST_AUX, SRC_V1, SRC_V1, 6'd0, 1'b0);
            6'd15: u = mk(OP_MUL, DST_V2, SRC_AUX, SRC_P6, 6'd0, 1'b0);
            6'd16: u = mk(OP_MUL, DST_AUX, SRC_V1, SRC_P5, 6'd0, 1'b0);
            6'd17: u = mk(OP_SHL, DST_AUX, SRC_AUX, SRC_ZERO, 6'd17, 1'b0);
            6'd18: u = mk(OP_ADD, DST_V2, SRC_V2, SRC_AUX, 6'd0, 1'b0);
            6'd19: u = mk(OP_SHL, DST_AUX, SRC_P4, SRC_ZERO, 6'd35, 1'b0);
            6'd20: u = mk(OP_ADD, DST_V2, SRC_V2, SRC_AUX, 6'd0, 1'b0);
            6'd21: u = mk(OP_MUL, DST_AUX, SRC_V1, SRC_V1, 6'd0, 1'b0);
            6'd22: u = mk(OP_MUL, DST_AUX, SRC_AUX, SRC_P3, 6'd0, 1'b0);
            6'd23: u = mk(OP_ASR, DST_AUX, SRC_AUX, SRC_ZERO, 6'd8, 1'b0);
            6'd24: u = mk(OP_MUL, DST_X, SRC_V1, SRC_P2, 6'd0, 1'b0);
            6'd25: u = mk(OP_SHL, DST_X, SRC_X, SRC_ZERO, 6'd12, 1'b0);
            6'd26: u = mk(OP_ADD, DST_V1, SRC_AUX, SRC_X, 6'd0, 1'b0);
            6'd27: u = mk(OP_ADD, DST_V1, SRC_V1, SRC_C2_47, 6'd0, 1'b0);
            6'd28: u = mk(OP_MUL, DST_V1, SRC_V1, SRC_P1, 6'd0, 1'b0);
            6'd29: u = mk(OP_ASR, DST_V1, SRC_V1, SRC_ZERO, 6'd33, 1'b0);
            6'd30: u = mk(OP_ZCHK, DST_V1, SRC_V1, SRC_ZERO, 6'd0, 1'b0);
            6'd31: u = mk(OP_SUB, DST_P, SRC_C1048576, SRC_ADC, 6'd0, 1'b0);
            6'd32: u = mk(OP_SHL, DST_P, SRC_P, SRC_ZERO, 6'd31, 1'b0);
            6'd33: u = mk(OP_SUB, DST_P, SRC_P, SRC_V2, 6'd0, 1'b0);
            6'd34: u = mk(OP_MUL, DST_P, SRC_P, SRC_C3125, 6'd0, 1'b0);
            6'd35: u = mk(OP_DIV, DST_P, SRC_P, SRC_V1, 6'd0, 1'b0);
            6'd36: u = mk(OP_ASR, DST_PS, SRC_P, SRC_ZERO, 6'd13, 1'b0);
            6'd37: u = mk(OP_MUL, DST_AUX, SRC_P9, SRC_PS, 6'd0, 1'b0);
            6'd38: u = mk(OP_MUL, DST_AUX, SRC_AUX, SRC_PS, 6'd0, 1'b0);
            6'd39: u = mk(OP_ASR, DST_V1, SRC_AUX, SRC_ZERO, 6'd25, 1'b0);
            6'd40: u = mk(OP_MUL, DST_V2, SRC_P8, SRC_P, 6'd0, 1'b0);
            6'd41: u = mk(OP_ASR, DST_V2, SRC_V2, SRC_ZERO, 6'd19, 1'b0);
            6'd42: u = mk(OP_ADD, DST_P, SRC_P, SRC_V1, 6'd0, 1'b0);
            6'd43: u = mk(OP_ADD, DST_P, SRC_P, SRC_V2, 6'd0, 1'b0);
            6'd44: u = mk(OP_ASR, DST_P, SRC_P, SRC_ZERO, 6'd8, 1'b0);
            6'd45: u = mk(OP_SHL, DST_AUX, SRC_P7, SRC_ZERO, 6'd4, 1'b0);
            6'd46: u = mk(OP_ADD, DST_P, SRC_P, SRC_AUX, 6'd0, 1'b0);
            default: u = mk(OP_DONE, DST_P, SRC_ZERO, SRC_ZERO, 6'd0, 1'b0);
        endcase
        return u;
    endfunction

endpackage

// ----- hw/rtl/bptc_alu.sv -----
// Shared 64-bit arithmetic unit: add, subtract, shifts, multi-cycle multiply and divide.
module bptc_alu
    import bptc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_alu_cmd    i_cmd,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_res
);
`include "assert_macros.svh"

    t_alu_st     r_st, n_st;
    logic [63:0] r_a, r_b, r_acc, r_rem, r_quo, r_res;
    logic [5:0]  r_cnt;
    logic        r_neg, r_done, n_done;

    logic [31:0] w_ma, w_mb;
    logic [63:0] w_prod, w_acc;
    logic [64:0] w_rsh, w_diff;

    // One 32x32 product per cycle; the wrapped 64-bit product sums three partial products.
    assign w_ma   = (r_cnt == 6'd2) ? r_a[63:32] : r_a[31:0];
    assign w_mb   = (r_cnt == 6'd1) ? r_b[63:32] : r_b[31:0];
    assign w_prod = 64'(w_ma) * 64'(w_mb);
    assign w_acc  = (r_cnt == 6'd0) ? w_prod : r_acc + {w_prod[31:0], 32'd0};

    // Restoring division, one quotient bit per cycle.
    assign w_rsh  = {r_rem, r_quo[63]};
    assign w_diff = w_rsh - {1'b0, r_b};

    always_comb begin
        n_st = r_st;
        case (r_st)
            ALU_IDLE: begin
                if (i_cmd.start && i_cmd.op == OP_MUL) n_st = ALU_MUL;
                else if (i_cmd.start && i_cmd.op == OP_DIV) n_st = ALU_DIV;
            end
            ALU_MUL: if (r_cnt == 6'd2) n_st = ALU_IDLE;
            ALU_DIV: if (r_cnt == 6'd63) n_st = ALU_FIX;
            ALU_FIX: n_st = ALU_IDLE;
            default: n_st = ALU_IDLE;
        endcase
    end

    // Add, subtract and the shifts finish straight from idle; multiply at its last step, divide in its fix-up state.
    always_comb begin
        n_done = 1'b0;
        case (r_st)
            ALU_IDLE: n_done = i_cmd.start && (i_cmd.op == OP_ADD || i_cmd.op == OP_SUB ||
                                               i_cmd.op == OP_ASR || i_cmd.op == OP_SHL);
            ALU_MUL:  n_done = (r_cnt == 6'd2);
            ALU_FIX:  n_done = 1'b1;
            default:  n_done = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ALU_IDLE;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_st   <= n_st;
            r_done <= n_done;
            case (r_st)
                ALU_IDLE: begin
                    r_cnt <= '0;
                    if (i_cmd.start) begin
                        case (i_cmd.op)
                            OP_ADD: r_res <= i_a + i_b;
                            OP_SUB: r_res <= i_a - i_b;
                            OP_ASR: r_res <= 64'($signed(i_a) >>> i_cmd.sh);
                            OP_SHL: r_res <= i_a << i_cmd.sh;
                            OP_MUL: begin r_a <= i_a; r_b <= i_b; end
                            OP_DIV: begin
                                r_quo <= i_a[63] ? 64'd0 - i_a : i_a;
                                r_b   <= i_b[63] ? 64'd0 - i_b : i_b;
                                r_neg <= i_a[63] ^ i_b[63];
                                r_rem <= '0;
                            end
                            default: r_res <= r_res;
                        endcase
                    end
                end
                ALU_MUL: begin
                    r_acc <= w_acc;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd2) begin
                        r_res <= w_acc;
                    end
                end
                ALU_DIV: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (!w_diff[64]) begin
                        r_rem <= w_diff[63:0];
                        r_quo <= {r_quo[62:0], 1'b1};
                    end else begin
                        r_rem <= w_rsh[63:0];
                        r_quo <= {r_quo[62:0], 1'b0};
                    end
                end
                ALU_FIX: begin
                    r_res <= r_neg ? 64'd0 - r_quo : r_quo;
                end
                default: r_cnt <= '0;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    `ASSERT_IMP(a_done_idle, i_clk, i_rst_n, r_done, r_st == ALU_IDLE)
    `ASSERT_NXT(a_fix_done, i_clk, i_rst_n, r_st == ALU_FIX, r_done)
    `ASSERT_IMP(a_mul_cnt, i_clk, i_rst_n, r_st == ALU_MUL, r_cnt <= 6'd2)

endmodule

// ----- hw/rtl/baro_temp_pressure_compensation_unit.sv -----
// Top level: barometric temperature and pressure compensation with a shared arithmetic unit.
//
//  Channel   Direction  Ports                 Payload
//  s_axis    in         tvalid/tready/tdata   tdata[19:0] raw_sample; tuser[0] req_type
//  m_axis    out        tvalid/tready/tdata   tdata[31:0] temperature_centi,
//                                             [63:32] pressure_q24_8, [64] divide_guard;
//                                             tuser[0] reading_kind
//  cfg       in         we/addr/data          register index 0..3, 64-bit data
//
// The time a request takes is set by the micro-op program length, the multiply built from
// partial products and the bit-by-bit restoring divide, all run through one shared
// arithmetic unit.
// A zero divisor ends a pressure request early, right after the divisor is formed.
// Reset is synchronous and active low; it clears the calibration registers, the
// stored fine temperature and all control state.
// The block takes one request at a time: tready is high only while it is idle, and a
// finished result waits in the output register until the downstream side takes it.
module baro_temp_pressure_compensation_unit
    import bptc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // [19:0] raw_sample, [23:20] zero
    input  logic [0:0]  i_s_axis_tuser,   // [0] req_type
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,   // [31:0] temperature_centi, [63:32] pressure_q24_8,
                                          // [64] divide_guard, [71:65] zero
    output logic [0:0]  o_m_axis_tuser,   // [0] reading_kind
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [63:0] i_cfg_data
);
`include "assert_macros.svh"

    // Calibration registers.
    logic [47:0] r_tcoef;
    logic [63:0] r_plow, r_phigh;
    logic [15:0] r_p9;

    // Working registers of the micro-op program.
    logic [63:0] r_v1, r_v2, r_p, r_aux, r_x, r_ps;
    logic [31:0] r_ft;
    logic [19:0] r_adc;
    logic        r_kind;
    logic [PC_W-1:0] r_pc;

    // Output register.
    logic [31:0] r_o_temp, r_o_press;
    logic        r_o_guard, r_o_kind;

    t_seq_st     r_st, n_st;
    t_uop        w_uop;
    t_alu_cmd    w_cmd;
    logic [63:0] w_a, w_b, w_res, w_wr;
    logic        w_done, w_zero, w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcoef <= '0;
            r_plow  <= '0;
            r_phigh <= '0;
            r_p9    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_TEMP:  r_tcoef <= i_cfg_data[47:0];
                CFG_PLOW:  r_plow  <= i_cfg_data;
                CFG_PHIGH: r_phigh <= i_cfg_data;
                CFG_PNINE: r_p9    <= i_cfg_data[15:0];
                default:   r_p9    <= r_p9;
            endcase
        end
    end

    function automatic logic [63:0] sx16(logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    // Operand selection for the shared unit.
    function automatic logic [63:0] src_val(t_src s);
        logic [63:0] v;
        case (s)
            SRC_V1:       v = r_v1;
            SRC_V2:       v = r_v2;
            SRC_P:        v = r_p;
            SRC_AUX:      v = r_aux;
            SRC_X:        v = r_x;
            SRC_PS:       v = r_ps;
            SRC_FTX:      v = {{32{r_ft[31]}}, r_ft};
            SRC_ADC:      v = {44'd0, r_adc};
            SRC_ADC_SH3:  v = {47'd0, r_adc[19:3]};
            SRC_ADC_SH4:  v = {48'd0, r_adc[19:4]};
            SRC_T1:       v = {48'd0, r_tcoef[15:0]};
            SRC_T1_SH1:   v = {47'd0, r_tcoef[15:0], 1'b0};
            SRC_T2:       v = sx16(r_tcoef[31:16]);
            SRC_T3:       v = sx16(r_tcoef[47:32]);
            SRC_P1:       v = {48'd0, r_plow[15:0]};
            SRC_P2:       v = sx16(r_plow[31:16]);
            SRC_P3:       v = sx16(r_plow[47:32]);
            SRC_P4:       v = sx16(r_plow[63:48]);
            SRC_P5:       v = sx16(r_phigh[15:0]);
            SRC_P6:       v = sx16(r_phigh[31:16]);
            SRC_P7:       v = sx16(r_phigh[47:32]);
            SRC_P8:       v = sx16(r_phigh[63:48]);
            SRC_P9:       v = sx16(r_p9);
            SRC_C5:       v = C_5;
            SRC_C128:     v = C_128;
            SRC_C128000:  v = C_128000;
            SRC_C1048576: v = C_1048576;
            SRC_C3125:    v = C_3125;
            SRC_C2_47:    v = C_2_POW_47;
            default:      v = '0;
        endcase
        return v;
    endfunction

    assign w_uop    = uop_rom(r_pc);

    // The operand mux reads the working registers directly, so it must
    // re-evaluate whenever any of them changes.
    always_comb begin
        w_a = src_val(w_uop.a);
        w_b = src_val(w_uop.b);
    end

    assign w_zero   = (r_v1 == 64'd0);
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    // Temperature steps wrap at 32 bits: keep the low word sign extended.
    assign w_wr     = w_uop.w32 ? {{32{w_res[31]}}, w_res[31:0]} : w_res;

    bptc_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_done  (w_done),
        .o_res   (w_res)
    );

    // Next state of the sequencer.
    always_comb begin
        n_st = r_st;
        case (r_st)
            SEQ_IDLE: if (w_accept) n_st = SEQ_ISSUE;
            SEQ_ISSUE: begin
                if (w_uop.op == OP_DONE) n_st = SEQ_OUT;
                else if (w_uop.op == OP_ZCHK) n_st = w_zero ? SEQ_OUT : SEQ_ISSUE;
                else n_st = SEQ_WAIT;
            end
            SEQ_WAIT: if (w_done) n_st = SEQ_ISSUE;
            SEQ_OUT:  if (i_m_axis_tready) n_st = SEQ_IDLE;
            default:  n_st = SEQ_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        w_cmd.start     = 1'b0;
        w_cmd.op        = w_uop.op;
        w_cmd.sh        = w_uop.sh;
        o_s_axis_tready = 1'b0;
        o_m_axis_tvalid = 1'b0;
        case (r_st)
            SEQ_IDLE:  o_s_axis_tready = 1'b1;
            SEQ_ISSUE: w_cmd.start = (w_uop.op != OP_DONE) && (w_uop.op != OP_ZCHK);
            SEQ_OUT:   o_m_axis_tvalid = 1'b1;
            default:   w_cmd.start = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= SEQ_IDLE;
            r_ft <= '0;
            r_pc <= '0;
        end else begin
            r_st <= n_st;
            case (r_st)
                SEQ_IDLE: begin
                    if (w_accept) begin
                        r_kind <= i_s_axis_tuser[0];
                        r_adc  <= i_s_axis_tdata[19:0];
                        r_pc   <= i_s_axis_tuser[0] ? PRESS_PC : TEMP_PC;
                    end
                end
                SEQ_ISSUE: begin
                    if (w_uop.op == OP_DONE) begin
                        r_o_kind  <= r_kind;
                        r_o_temp  <= r_kind ? 32'd0 : r_p[31:0];
                        r_o_press <= r_kind ? r_p[31:0] : 32'd0;
                        r_o_guard <= 1'b0;
                    end else if (w_uop.op == OP_ZCHK) begin
                        if (w_zero) begin
                            // Zero divisor: pressure is forced to zero and flagged.
                            r_o_kind  <= r_kind;
                            r_o_temp  <= 32'd0;
                            r_o_press <= 32'd0;
                            r_o_guard <= 1'b1;
                        end else begin
                            r_pc <= r_pc + PC_W'(1);
                        end
                    end
                end
                SEQ_WAIT: begin
                    if (w_done) begin
                        r_pc <= r_pc + PC_W'(1);
                        case (w_uop.dst)
                            DST_V1:  r_v1  <= w_wr;
                            DST_V2:  r_v2  <= w_wr;
                            DST_P:   r_p   <= w_wr;
                            DST_AUX: r_aux <= w_wr;
                            DST_X:   r_x   <= w_wr;
                            DST_PS:  r_ps  <= w_wr;
                            DST_FT:  r_ft  <= w_wr[31:0];
                            default: r_aux <= w_wr;
                        endcase
                    end
                end
                default: r_pc <= r_pc;
            endcase
        end
    end

    assign o_m_axis_tdata = {7'd0, r_o_guard, r_o_press, r_o_temp};
    assign o_m_axis_tuser = r_o_kind;

    `ASSERT_IMP(a_one_side, i_clk, i_rst_n, o_s_axis_tready, !o_m_axis_tvalid)
    `ASSERT_IMP(a_temp_clean, i_clk, i_rst_n, o_m_axis_tvalid && !r_o_kind, r_o_press == 32'd0 && !r_o_guard)
    `ASSERT_IMP(a_guard_zero, i_clk, i_rst_n, o_m_axis_tvalid && r_o_guard, r_o_press == 32'd0 && r_o_kind)
    `ASSERT_NXT(a_wait_busy, i_clk, i_rst_n, r_st == SEQ_ISSUE && w_cmd.start, r_st == SEQ_WAIT)

endmodule
